// ----- rtl/peshp_pkg.sv -----
// Shared types and constants for the PES header parser.
// Holds the transfer structs, status codes, parse phases and derived widths.
// No dependencies.
`default_nettype none

package peshp_pkg;

   localparam int MAX_STUFFING    = 16;
   localparam int MAX_HEADER_DATA = 64;

   localparam int NEED_MAX = 9 + MAX_STUFFING + MAX_HEADER_DATA;
   localparam int IDX_W    = $clog2(NEED_MAX + 1);
   localparam int STUFF_W  = $clog2(MAX_STUFFING + 2);
   localparam int TS_W     = 33;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_SHORT    = 3'd1;
   localparam logic [2:0] ST_TOO_LONG = 3'd2;
   localparam logic [2:0] ST_BAD_PTS  = 3'd3;
   localparam logic [2:0] ST_BAD_DTS  = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]      status;
      logic [6:0]      hdr_size;
      logic [15:0]     pkt_size;
      logic [7:0]      sid;
      logic            is_mpeg2;
      logic            has_pts;
      logic            has_dts;
      logic [TS_W-1:0] pts;
      logic [TS_W-1:0] dts;
   } rsp_type;

   typedef struct packed {
      logic            bad;
      logic [TS_W-1:0] value;
   } ts_type;

   typedef enum logic [6:0] {
      PH_FIXED    = 7'b0000001,
      PH_STUFF    = 7'b0000010,
      PH_M2_FLAGS = 7'b0000100,
      PH_M2_LEN   = 7'b0001000,
      PH_M1_BUF   = 7'b0010000,
      PH_M1_FLAGS = 7'b0100000,
      PH_TAIL     = 7'b1000000
   } phase_type;

endpackage

`default_nettype wire

// ----- rtl/pes_header_parser_core.sv -----
// Top level of the PES header parser: input register, parse stage, result register.
// Depends on peshp_pkg and peshp_parser.
//
// Takes one packet byte per transfer, start code first, with last_byte set on the
// final byte available, and gives one result per packet: stream id, packet length,
// MPEG-2 or MPEG-1 layout, header length and the 33-bit PTS and DTS with their
// marker checks. Sustained rate is one byte per clock while no result is held.
// A byte passes through the input register, is parsed against the per-packet state,
// and its result, if any, is then loaded into the result register.
// While the result register is held by rsp_stall, one more byte is buffered and
// req_stall then rises. Bytes after the result up to the flagged last byte are
// consumed and dropped; the byte after that starts a new packet.
`default_nettype none

module pes_header_parser_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire peshp_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output peshp_pkg::rsp_type      rsp_data
);

   logic               in_valid_ff;
   peshp_pkg::req_type in_item_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   peshp_pkg::rsp_type rsp_data_ff;
   logic               advance;
   logic               parse_fire;
   peshp_pkg::rsp_type parse_result;

   assign advance   = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_data;
      end
   end

   peshp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item       (in_item_ff),
      .fire       (parse_fire),
      .result     (parse_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (parse_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (parse_fire) begin
         rsp_data_ff <= parse_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      parse_fire |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while held");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != peshp_pkg::ST_OK) |->
         (rsp_data.hdr_size == 7'd0 && !rsp_data.has_pts && !rsp_data.has_dts))
      else $error("error result carries header data");

   a_ts_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.has_pts || rsp_data.pts == '0) &&
                     (rsp_data.has_dts || rsp_data.dts == '0)))
      else $error("absent timestamp is not zero");
`endif

endmodule

`default_nettype wire

// ----- rtl/peshp_ts_field.sv -----
// Timestamp accumulator: assembles one 33-bit PTS or DTS from five bytes
// and tracks its marker bits. Depends on peshp_pkg.
`default_nettype none

module peshp_ts_field (
   input  wire logic              clock,
   input  wire logic              clear,
   input  wire logic              feed,
   input  wire logic [2:0]        pos,
   input  wire logic [7:0]        data_byte,
   output peshp_pkg::ts_type      ts_next
);

   peshp_pkg::ts_type ts_ff;
   peshp_pkg::ts_type ts_in;

   always_comb begin
      ts_in = ts_ff;
      if (feed) begin
         case (pos)
            3'd0: begin
               ts_in.value = {30'd0, data_byte[3:1]};
               if (data_byte[5:4] == 2'b00) ts_in.bad = 1'b1;
            end
            3'd1, 3'd3: begin
               ts_in.value = {ts_ff.value[24:0], data_byte};
            end
            3'd2, 3'd4: begin
               ts_in.value = {ts_ff.value[25:0], data_byte[7:1]};
               if (!data_byte[0]) ts_in.bad = 1'b1;
            end
            default: begin
               ts_in = ts_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         ts_ff <= '0;
      end else begin
         ts_ff <= ts_in;
      end
   end

   assign ts_next = ts_in;

endmodule

`default_nettype wire

// ----- rtl/peshp_parser.sv -----
// Header parse stage: per-packet state, layout decoding and result build.
// Depends on peshp_pkg and peshp_ts_field.
`default_nettype none

module peshp_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire peshp_pkg::req_type item,
   output logic                    fire,
   output peshp_pkg::rsp_type      result
);

   localparam int IDX_W   = peshp_pkg::IDX_W;
   localparam int STUFF_W = peshp_pkg::STUFF_W;

   localparam logic [IDX_W-1:0]   IDX_SID       = IDX_W'(3);
   localparam logic [IDX_W-1:0]   IDX_LEN_HI    = IDX_W'(4);
   localparam logic [IDX_W-1:0]   IDX_LEN_LO    = IDX_W'(5);
   localparam logic [IDX_W-1:0]   NEED_MIN      = IDX_W'(9);
   localparam logic [IDX_W-1:0]   HDR_FIXED     = IDX_W'(6);
   localparam logic [STUFF_W-1:0] STUFF_LIMIT   = STUFF_W'(peshp_pkg::MAX_STUFFING);
   localparam logic [7:0]         HDR_DATA_LIMIT = 8'(peshp_pkg::MAX_HEADER_DATA);

   function automatic logic [IDX_W-1:0] at_least_nine(input logic [IDX_W-1:0] n);
      return (n > NEED_MIN) ? n : NEED_MIN;
   endfunction

   peshp_pkg::phase_type phase_ff, phase_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [STUFF_W-1:0]   stuff_ff, stuff_in;
   logic [7:0]           sid_ff, sid_in;
   logic [15:0]          pkt_len_ff, pkt_len_in;
   logic [IDX_W-1:0]     need_ff, need_in;
   logic [IDX_W-1:0]     hdr_len_ff, hdr_len_in;
   logic [IDX_W-1:0]     ts_base_ff, ts_base_in;
   logic                 mpeg2_ff, mpeg2_in;
   logic                 pts_on_ff, pts_on_in;
   logic                 dts_on_ff, dts_on_in;
   logic                 given_ff;

   logic [7:0]           d;
   logic                 step;
   logic                 restart;
   logic                 clear;
   logic                 too_long;
   logic                 done;
   logic                 ok;
   logic [2:0]           status;
   logic                 pts_feed, dts_feed;
   logic [2:0]           pts_pos, dts_pos;
   logic [IDX_W-1:0]     rel;
   logic                 m1_top_zero, m1_pts, m1_dts;
   logic [IDX_W-1:0]     m1_n, m1_need, m1_hdr_add;
   logic [IDX_W-1:0]     m2_n;
   peshp_pkg::ts_type    pts_next, dts_next;

   assign d    = item.data_byte;
   assign step = item_valid && !given_ff;

   always_comb begin
      m1_top_zero = (d[7:6] == 2'b00);
      m1_pts      = m1_top_zero && d[5];
      m1_dts      = m1_top_zero && d[4];
      if (m1_dts) begin
         m1_n = IDX_W'(10);
      end else if (m1_pts) begin
         m1_n = IDX_W'(5);
      end else begin
         m1_n = IDX_W'(1);
      end
      m1_need    = at_least_nine(idx_ff + m1_n);
      m1_hdr_add = m1_top_zero ?
                   ((m1_pts ? IDX_W'(4) : '0) + (m1_dts ? IDX_W'(5) : '0) + IDX_W'(1)) : '0;
   end

   always_comb begin
      m2_n = IDX_W'(d);
      if (pts_on_ff && m2_n < IDX_W'(5)) m2_n = IDX_W'(5);
      if (dts_on_ff && m2_n < IDX_W'(10)) m2_n = IDX_W'(10);
   end

   always_comb begin
      phase_in     = phase_ff;
      idx_in       = (&idx_ff) ? idx_ff : idx_ff + IDX_W'(1);
      stuff_in     = stuff_ff;
      sid_in       = sid_ff;
      pkt_len_in   = pkt_len_ff;
      need_in      = need_ff;
      hdr_len_in   = hdr_len_ff;
      ts_base_in   = ts_base_ff;
      mpeg2_in     = mpeg2_ff;
      pts_on_in    = pts_on_ff;
      dts_on_in    = dts_on_ff;
      too_long     = 1'b0;
      pts_feed     = 1'b0;
      pts_pos      = 3'd0;
      dts_feed     = 1'b0;
      dts_pos      = 3'd0;
      rel          = '0;
      unique case (phase_ff)
         peshp_pkg::PH_FIXED: begin
            if (idx_ff == IDX_SID) begin
               sid_in = d;
            end else if (idx_ff == IDX_LEN_HI) begin
               pkt_len_in[15:8] = d;
            end else if (idx_ff == IDX_LEN_LO) begin
               pkt_len_in[7:0] = d;
               phase_in        = peshp_pkg::PH_STUFF;
            end
         end
         peshp_pkg::PH_STUFF: begin
            if (d == 8'hFF && stuff_ff < STUFF_LIMIT) begin
               stuff_in = stuff_ff + STUFF_W'(1);
            end else begin
               hdr_len_in = HDR_FIXED + IDX_W'(stuff_ff);
               if (d[7:6] == 2'b10) begin
                  mpeg2_in = 1'b1;
                  phase_in = peshp_pkg::PH_M2_FLAGS;
               end else if (d[7:6] == 2'b01) begin
                  phase_in = peshp_pkg::PH_M1_BUF;
               end else begin
                  hdr_len_in = HDR_FIXED + IDX_W'(stuff_ff) + m1_hdr_add;
                  pts_on_in  = m1_pts;
                  dts_on_in  = m1_dts;
                  ts_base_in = idx_ff;
                  pts_feed   = m1_pts;
                  need_in    = m1_need;
                  phase_in   = peshp_pkg::PH_TAIL;
               end
            end
         end
         peshp_pkg::PH_M2_FLAGS: begin
            pts_on_in = d[7];
            dts_on_in = d[6];
            phase_in  = peshp_pkg::PH_M2_LEN;
         end
         peshp_pkg::PH_M2_LEN: begin
            if (d > HDR_DATA_LIMIT) begin
               too_long = 1'b1;
            end else begin
               hdr_len_in = hdr_len_ff + IDX_W'(3) + IDX_W'(d);
               ts_base_in = idx_ff + IDX_W'(1);
               need_in    = at_least_nine(idx_ff + IDX_W'(1) + m2_n);
               phase_in   = peshp_pkg::PH_TAIL;
            end
         end
         peshp_pkg::PH_M1_BUF: begin
            phase_in = peshp_pkg::PH_M1_FLAGS;
         end
         peshp_pkg::PH_M1_FLAGS: begin
            hdr_len_in = hdr_len_ff + IDX_W'(2) + m1_hdr_add;
            pts_on_in  = m1_pts;
            dts_on_in  = m1_dts;
            ts_base_in = idx_ff;
            pts_feed   = m1_pts;
            need_in    = m1_need;
            phase_in   = peshp_pkg::PH_TAIL;
         end
         peshp_pkg::PH_TAIL: begin
            if (idx_ff >= ts_base_ff) begin
               rel = idx_ff - ts_base_ff;
               if (pts_on_ff && rel < IDX_W'(5)) begin
                  pts_feed = 1'b1;
                  pts_pos  = rel[2:0];
               end
               if (dts_on_ff && rel >= IDX_W'(5) && rel < IDX_W'(10)) begin
                  dts_feed = 1'b1;
                  dts_pos  = 3'(rel - IDX_W'(5));
               end
            end
         end
         default: begin
            phase_in = peshp_pkg::PH_FIXED;
         end
      endcase
   end

   always_comb begin
      done = (phase_in == peshp_pkg::PH_TAIL) && (idx_in >= need_in);
      fire = step && (too_long || done || item.last_byte);
      ok   = 1'b0;
      if (too_long) begin
         status = peshp_pkg::ST_TOO_LONG;
      end else if (done) begin
         if (pts_on_in && pts_next.bad) begin
            status = peshp_pkg::ST_BAD_PTS;
         end else if (dts_on_in && dts_next.bad) begin
            status = peshp_pkg::ST_BAD_DTS;
         end else begin
            status = peshp_pkg::ST_OK;
            ok     = 1'b1;
         end
      end else begin
         status = peshp_pkg::ST_SHORT;
      end
      result.status   = status;
      result.hdr_size = ok ? 7'(hdr_len_in) : 7'd0;
      result.pkt_size = pkt_len_in;
      result.sid      = sid_in;
      result.is_mpeg2 = mpeg2_in;
      result.has_pts  = ok && pts_on_in;
      result.has_dts  = ok && dts_on_in;
      result.pts      = (ok && pts_on_in) ? pts_next.value : '0;
      result.dts      = (ok && dts_on_in) ? dts_next.value : '0;
   end

   assign restart = item_valid && item.last_byte && (given_ff || fire);
   assign clear   = reset || restart;

   peshp_ts_field u_pts (
      .clock     (clock),
      .clear     (clear),
      .feed      (step && pts_feed),
      .pos       (pts_pos),
      .data_byte (d),
      .ts_next   (pts_next)
   );

   peshp_ts_field u_dts (
      .clock     (clock),
      .clear     (clear),
      .feed      (step && dts_feed),
      .pos       (dts_pos),
      .data_byte (d),
      .ts_next   (dts_next)
   );

   always_ff @(posedge clock) begin
      if (clear) begin
         phase_ff     <= peshp_pkg::PH_FIXED;
         idx_ff       <= '0;
         stuff_ff     <= '0;
         sid_ff       <= '0;
         pkt_len_ff   <= '0;
         need_ff      <= NEED_MIN;
         hdr_len_ff   <= '0;
         ts_base_ff   <= '0;
         mpeg2_ff     <= 1'b0;
         pts_on_ff    <= 1'b0;
         dts_on_ff    <= 1'b0;
         given_ff     <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         stuff_ff     <= stuff_in;
         sid_ff       <= sid_in;
         pkt_len_ff   <= pkt_len_in;
         need_ff      <= need_in;
         hdr_len_ff   <= hdr_len_in;
         ts_base_ff   <= ts_base_in;
         mpeg2_ff     <= mpeg2_in;
         pts_on_ff    <= pts_on_in;
         dts_on_ff    <= dts_on_in;
         given_ff     <= fire;
      end
   end

endmodule

`default_nettype wire

// ----- sim/pes_header_parser_core_test.sv -----
// Self-checking testbench for pes_header_parser_core: packet bytes in, header results out.
// Depends on peshp_pkg and the pes_header_parser_core RTL with peshp_parser and peshp_ts_field.

module pes_header_parser_core_test;
   import peshp_pkg::*;

   localparam int ITEMS       = 1950;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       typed;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   dir_row_type dir_tbl [31] = '{
      '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h01, 1'b1, 1'b1},
      '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0},
      '{8'hE0, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
      '{8'h80, 1'b0, 1'b0}, '{8'hC0, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b1},
      '{8'h00, 1'b1, 1'b0},
      '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0},
      '{8'hC0, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h10, 1'b0, 1'b0},
      '{8'h40, 1'b0, 1'b0}, '{8'hA5, 1'b0, 1'b0}, '{8'h31, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0}, '{8'hFE, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0}, '{8'h11, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h01, 1'b1, 1'b1}
   };

   rsp_type dir_want [3] = '{
      '{ST_SHORT,    7'd0, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 33'd0, 33'd0},
      '{ST_TOO_LONG, 7'd0, 16'hFFFF, 8'hE0, 1'b1, 1'b0, 1'b0, 33'd0, 33'd0},
      '{ST_BAD_PTS,  7'd0, 16'h0010, 8'hC0, 1'b0, 1'b0, 1'b0, 33'd0, 33'd0}
   };

   rsp_type    pending_headers [$];
   logic [7:0] pkt [$];
   int         item_count;
   int         typed_used;
   int         error_count;
   int         cycle_count;
   int         send_idle_pct;
   int         rcv_idle_pct;
   bit         hold_request;

   // parser state mirror
   int          p_idx, p_stuff, p_need, p_hdr, p_base;
   phase_type   p_phase;
   logic [7:0]  p_sid;
   logic [15:0] p_plen;
   logic [32:0] p_pts, p_dts;
   bit          p_done, p_m2, p_pts_on, p_dts_on, p_pts_bad, p_dts_bad;

   pes_header_parser_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   function automatic void clear_parse();
      p_idx = 0;
      p_stuff = 0;
      p_need = 9;
      p_hdr = 0;
      p_base = 0;
      p_phase = PH_FIXED;
      p_sid = '0;
      p_plen = '0;
      p_pts = '0;
      p_dts = '0;
      p_done = 1'b0;
      p_m2 = 1'b0;
      p_pts_on = 1'b0;
      p_dts_on = 1'b0;
      p_pts_bad = 1'b0;
      p_dts_bad = 1'b0;
   endfunction

   function automatic void feed_ts(inout logic [32:0] acc, inout bit bad, input int k,
                                   input logic [7:0] d);
      case (k)
         0: begin
            if (d[5:4] == 2'b00) bad = 1'b1;
            acc = {30'd0, d[3:1]};
         end
         1, 3: acc = {acc[24:0], d};
         2, 4: begin
            if (!d[0]) bad = 1'b1;
            acc = {acc[25:0], d[7:1]};
         end
         default: ;
      endcase
   endfunction

   function automatic void set_need(input int n);
      p_need = (n > 9) ? n : 9;
      p_phase = PH_TAIL;
   endfunction

   function automatic void mpeg1_flags(input int idx, input logic [7:0] d);
      int n;
      if (d[7:6] != 2'b00) begin
         p_pts_on = 1'b0;
         p_dts_on = 1'b0;
         set_need(idx + 1);
      end else begin
         p_pts_on = d[5];
         p_dts_on = d[4];
         p_base = idx;
         p_hdr += (p_pts_on ? 4 : 0) + (p_dts_on ? 5 : 0) + 1;
         n = p_dts_on ? 10 : (p_pts_on ? 5 : 1);
         if (p_pts_on) feed_ts(p_pts, p_pts_bad, 0, d);
         set_need(idx + n);
      end
   endfunction

   function automatic bit parse_byte(input logic [7:0] d, input bit lst, output rsp_type r);
      int         idx;
      int         n;
      int         rel;
      logic [2:0] st;
      bit         too_long;
      bit         ok;
      idx = p_idx;
      st = ST_SHORT;
      too_long = 1'b0;
      ok = 1'b0;
      r = '0;
      if (p_done) begin
         if (lst) clear_parse();
         return 1'b0;
      end
      case (p_phase)
         PH_FIXED: begin
            if (idx == 3) p_sid = d;
            else if (idx == 4) p_plen[15:8] = d;
            else if (idx == 5) begin
               p_plen[7:0] = d;
               p_phase = PH_STUFF;
            end
         end
         PH_STUFF: begin
            if (d == 8'hFF && p_stuff < MAX_STUFFING) begin
               p_stuff++;
            end else begin
               p_hdr = 6 + p_stuff;
               if (d[7:6] == 2'b10) begin
                  p_m2 = 1'b1;
                  p_phase = PH_M2_FLAGS;
               end else if (d[7:6] == 2'b01) begin
                  p_phase = PH_M1_BUF;
               end else begin
                  mpeg1_flags(idx, d);
               end
            end
         end
         PH_M2_FLAGS: begin
            p_pts_on = d[7];
            p_dts_on = d[6];
            p_phase = PH_M2_LEN;
         end
         PH_M2_LEN: begin
            if (d > MAX_HEADER_DATA) begin
               too_long = 1'b1;
            end else begin
               p_hdr += 3 + d;
               p_base = idx + 1;
               n = d;
               if (p_pts_on && n < 5) n = 5;
               if (p_dts_on && n < 10) n = 10;
               set_need(idx + 1 + n);
            end
         end
         PH_M1_BUF: p_phase = PH_M1_FLAGS;
         PH_M1_FLAGS: begin
            p_hdr += 2;
            mpeg1_flags(idx, d);
         end
         default: begin
            if (idx >= p_base) begin
               rel = idx - p_base;
               if (p_pts_on && rel < 5) feed_ts(p_pts, p_pts_bad, rel, d);
               if (p_dts_on && rel >= 5 && rel < 10) feed_ts(p_dts, p_dts_bad, rel - 5, d);
            end
         end
      endcase
      if (p_idx < 16'hFFFF) p_idx++;
      if (too_long) begin
         st = ST_TOO_LONG;
      end else if (p_phase == PH_TAIL && p_idx >= p_need) begin
         if (p_pts_on && p_pts_bad) st = ST_BAD_PTS;
         else if (p_dts_on && p_dts_bad) st = ST_BAD_DTS;
         else begin
            st = ST_OK;
            ok = 1'b1;
         end
      end else if (!lst) begin
         return 1'b0;
      end
      r.status = st;
      r.hdr_size = ok ? 7'(p_hdr) : 7'd0;
      r.pkt_size = p_plen;
      r.sid = p_sid;
      r.is_mpeg2 = p_m2;
      r.has_pts = ok && p_pts_on;
      r.has_dts = ok && p_dts_on;
      r.pts = (ok && p_pts_on) ? p_pts : '0;
      r.dts = (ok && p_dts_on) ? p_dts : '0;
      if (lst) clear_parse();
      else p_done = 1'b1;
      return 1'b1;
   endfunction

   function automatic logic [32:0] random_ts();
      case ($urandom_range(7))
         0: return '1;
         1: return '0;
         default: return {1'($urandom), 32'($urandom)};
      endcase
   endfunction

   function automatic logic [39:0] encode_ts(input logic [3:0] prefix, input logic [32:0] v);
      logic [39:0] b;
      b = {prefix, v[32:30], 1'b1, v[29:22], v[21:15], 1'b1, v[14:7], v[6:0], 1'b1};
      case ($urandom_range(15))
         0: b[37:36] = 2'b00;
         1: b[16] = 1'b0;
         2: b[0] = 1'b0;
         default: ;
      endcase
      return b;
   endfunction

   task automatic push_ts_area(input bit pf, input bit df, input logic [39:0] pb,
                               input logic [39:0] db, input int first, input int fill);
      for (int i = first; i < fill; i++) begin
         if (pf && i < 5) pkt.push_back(pb[39 - 8 * i -: 8]);
         else if (df && i >= 5 && i < 10) pkt.push_back(db[39 - 8 * (i - 5) -: 8]);
         else pkt.push_back(8'($urandom));
      end
   endtask

   task automatic build_packet();
      int          kind, nstuff, hl, need, fill, cut;
      bit          pf, df;
      logic [39:0] pb, db;
      pkt.delete();
      kind = $urandom_range(99);
      if ($urandom_range(7) == 0) begin
         repeat (3) pkt.push_back(8'($urandom));
      end else begin
         pkt.push_back(8'h00);
         pkt.push_back(8'h00);
         pkt.push_back(8'h01);
      end
      repeat (3) pkt.push_back(8'($urandom));
      nstuff = ($urandom_range(3) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 2);
      repeat (nstuff) pkt.push_back(8'hFF);
      pf = 1'($urandom_range(1));
      df = 1'($urandom_range(1));
      pb = encode_ts({2'($urandom), 2'($urandom_range(1, 3))}, random_ts());
      db = encode_ts({2'($urandom), 2'($urandom_range(1, 3))}, random_ts());
      need = df ? 10 : (pf ? 5 : 0);
      if (kind < 10) begin
         repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom));
      end else if (kind < 55) begin
         pkt.push_back({2'b10, 6'($urandom)});
         pkt.push_back({pf, df, 6'($urandom)});
         case ($urandom_range(15))
            0: hl = $urandom_range(65, 255);
            1: hl = MAX_HEADER_DATA;
            2, 3: hl = $urandom_range(0, need);
            default: hl = need + $urandom_range(0, 6);
         endcase
         pkt.push_back(8'(hl));
         fill = (hl > MAX_HEADER_DATA) ? 2 : ((hl > need) ? hl : need);
         push_ts_area(pf, df, pb, db, 0, fill);
      end else begin
         if ($urandom_range(1)) begin
            pkt.push_back({2'b01, 6'($urandom)});
            pkt.push_back(8'($urandom));
         end
         if ($urandom_range(7) == 0) begin
            pkt.push_back({2'($urandom_range(1, 3)), 6'($urandom)});
         end else begin
            pkt.push_back({2'b00, pf, df, pb[35:33], 1'($urandom)});
            push_ts_area(pf, df, pb, db, 1, need);
         end
      end
      repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
      if ($urandom_range(9) == 0) begin
         cut = $urandom_range(1, pkt.size());
         pkt = pkt[0:cut - 1];
      end
   endtask

   // call at a falling edge; returns at the falling edge after the transfer
   task automatic offer(input logic [7:0] b, input bit lst, input bit typed);
      rsp_type got;
      bit      emit;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: b, last_byte: lst};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      emit = parse_byte(b, lst, got);
      item_count++;
      if (typed) pending_headers.push_back(dir_want[typed_used++]);
      else if (emit) pending_headers.push_back(got);
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_headers.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected header result: %p", rsp_data);
         end else begin
            want = pending_headers.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.hdr_size !== want.hdr_size ||
                rsp_data.pkt_size !== want.pkt_size ||
                rsp_data.sid !== want.sid ||
                rsp_data.is_mpeg2 !== want.is_mpeg2 ||
                rsp_data.has_pts !== want.has_pts ||
                rsp_data.has_dts !== want.has_dts ||
                rsp_data.pts !== want.pts ||
                rsp_data.dts !== want.dts) begin
               error_count++;
               if (error_count <= 10)
                  $display("header result mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   initial begin
      int target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      send_idle_pct = 0;
      rcv_idle_pct = 0;
      hold_request = 1'b0;
      item_count = 0;
      typed_used = 0;
      error_count = 0;
      cycle_count = 0;
      clear_parse();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tbl[i]) offer(dir_tbl[i].data, dir_tbl[i].last, dir_tbl[i].typed);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 29 : ((ph == 1) ? 52 : 0);
         rcv_idle_pct = (ph == 0) ? 52 : ((ph == 1) ? 29 : 0);
         if (ph == 2) hold_request = 1'b1;
         target = item_count + ITEMS / 3;
         while (item_count < target) begin
            build_packet();
            foreach (pkt[i]) offer(pkt[i], i == pkt.size() - 1, 1'b0);
         end
      end
      req_valid <= 1'b0;

      while (pending_headers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_headers.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
